// File: sv/rpt_pkg.sv
// Shared types and constants for the rigid pose transform block.
// No dependencies; compiled first.
package rpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;   // default saturation width
    localparam int FIELD_W         = 32;   // coordinate field width
    localparam int CFG_W           = 32;   // register data width
    localparam int NUM_REGS        = 7;
    localparam int ADDR_W          = 5;    // byte address, registers at 4*i
    localparam int IDX_W           = 3;
    localparam int NSTG            = 6;    // pipeline depth

    // Internal fixed-point widths (bounds follow from |q| <= 2^30)
    localparam int P1_W = 64;              // q * v
    localparam int T_W  = 35;              // t = 2 * (q_im x v), |t| <= 2^33
    localparam int P2_W = 67;              // q * t
    localparam int R_W  = 37;              // v + rotated terms + translation

    localparam logic signed [FIELD_W-1:0] Q_ONE = 32'sh4000_0000;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_DIR   = 1'b1;

    typedef logic signed [FIELD_W-1:0] t_coord;

    typedef enum logic [IDX_W-1:0] {
        REG_ROT_X = 3'd0,
        REG_ROT_Y = 3'd1,
        REG_ROT_Z = 3'd2,
        REG_ROT_W = 3'd3,
        REG_POS_X = 3'd4,
        REG_POS_Y = 3'd5,
        REG_POS_Z = 3'd6
    } t_reg_idx;

    // Vector plus command, carried alongside the arithmetic
    typedef struct packed {
        logic   cmd;
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

endpackage

// File: sv/rpt_if.sv
// Valid/ready channel interfaces for the rigid pose transform.
// Depends on rpt_pkg.
interface rpt_in_if;
    import rpt_pkg::*;
    logic   valid;
    logic   ready;
    logic   cmd;
    t_coord in_x;
    t_coord in_y;
    t_coord in_z;

    modport source (output valid, cmd, in_x, in_y, in_z, input ready);
    modport sink   (input valid, cmd, in_x, in_y, in_z, output ready);
endinterface

interface rpt_out_if;
    import rpt_pkg::*;
    logic   valid;
    logic   ready;
    t_coord out_x;
    t_coord out_y;
    t_coord out_z;
    logic   overflow;

    modport source (output valid, out_x, out_y, out_z, overflow, input ready);
    modport sink   (input valid, out_x, out_y, out_z, overflow, output ready);
endinterface

// File: sv/rigid_pose_transform.sv
// Rigid pose transform: rotates Q16.16 vectors by a Q1.30 quaternion and
// adds a translation. Depends on rpt_pkg and rpt_if.
//
// Usage
//   i_in  : input words {cmd, in_x, in_y, in_z}; cmd = 0 point (rotate and
//           translate), cmd = 1 direction (rotate only).
//   o_out : result words {out_x, out_y, out_z, overflow}; each component is
//           clamped to COORD_WIDTH signed bits, overflow flags any clamp.
//   APB   : seven 32-bit registers at byte offsets 0x00..0x18 (rot_x, rot_y,
//           rot_z, rot_w, pos_x, pos_y, pos_z). pready is tied high. Write
//           only while no word is in flight.
// Pipeline and throughput
//   Six register stages: products, cross product, products, rounding, sum,
//   saturate/output. A word passes them in that order, and o_out is driven
//   from the last. One word per cycle sustained while o_out.ready stays high;
//   the rate is set by the pipelined 32x32 and 32x35 multipliers, one product
//   each per cycle.
// Reset
//   Synchronous, active low. Clears all stage valid bits and loads the
//   identity pose (w = 1.0, everything else 0).
// Back-pressure
//   Each stage advances when it is empty or the next one advances, so
//   bubbles are squeezed out and nothing is dropped or repeated while the
//   receiver holds o_out.ready low.
module rigid_pose_transform #(
    parameter int COORD_WIDTH = rpt_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rpt_in_if.sink                      i_in,
    rpt_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpt_pkg::ADDR_W-1:0]  paddr,
    input  logic [rpt_pkg::CFG_W-1:0]   pwdata,
    output logic [rpt_pkg::CFG_W-1:0]   prdata,
    output logic                        pready
);
    import rpt_pkg::*;

    // stage numbers
    localparam int S_MUL1  = 0;
    localparam int S_CROSS = 1;
    localparam int S_MUL2  = 2;
    localparam int S_RND   = 3;
    localparam int S_SUM   = 4;
    localparam int S_OUT   = 5;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    // round(p / 2^29), ties away from zero: add half, minus one if negative
    function automatic logic signed [T_W-1:0] rnd29(input logic signed [P1_W-1:0] p);
        logic signed [P1_W-1:0] s;
        s = p + (P1_W'(1) <<< 28) - P1_W'({1'b0, p[P1_W-1]});
        return s[29 +: T_W];
    endfunction

    function automatic logic signed [T_W-1:0] rnd30(input logic signed [P2_W-1:0] p);
        logic signed [P2_W-1:0] s;
        s = p + (P2_W'(1) <<< 29) - P2_W'({1'b0, p[P2_W-1]});
        return s[30 +: T_W];
    endfunction

    function automatic t_coord clamp_q(input t_coord v);
        t_coord c;
        c = v;
        if (v > Q_ONE) c = Q_ONE;
        if (v < -Q_ONE) c = -Q_ONE;
        return c;
    endfunction

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    logic [CFG_W-1:0] r_cfg [NUM_REGS];
    logic [IDX_W-1:0] w_idx;
    logic             w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
            r_cfg[REG_ROT_W] <= Q_ONE;
        end else if (w_wr) begin
            case (t_reg_idx'(w_idx))
                REG_ROT_X, REG_ROT_Y, REG_ROT_Z, REG_ROT_W,
                REG_POS_X, REG_POS_Y, REG_POS_Z: begin
                    r_cfg[w_idx] <= pwdata;
                end
                default: ;  // beyond the register list: dropped
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(w_idx))
            REG_ROT_X, REG_ROT_Y, REG_ROT_Z, REG_ROT_W,
            REG_POS_X, REG_POS_Y, REG_POS_Z: begin
                prdata = r_cfg[w_idx];
            end
            default: prdata = '0;
        endcase
    end

    // Quaternion components clamped to +-1.0 at use; registers keep raw value
    t_coord w_qx, w_qy, w_qz, w_qw;
    assign w_qx = clamp_q(t_coord'(r_cfg[REG_ROT_X]));
    assign w_qy = clamp_q(t_coord'(r_cfg[REG_ROT_Y]));
    assign w_qz = clamp_q(t_coord'(r_cfg[REG_ROT_Z]));
    assign w_qw = clamp_q(t_coord'(r_cfg[REG_ROT_W]));

    //------------------------------------------------------------------
    // Pipeline flow control
    //------------------------------------------------------------------
    logic [NSTG-1:0] r_vld, n_vld, w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld[0] = w_en[0] ? i_in.valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // vector and command ride along through stages S_MUL1..S_RND
    t_vec r_vec [S_RND + 1];
    t_vec n_vec0;
    assign n_vec0 = '{cmd: i_in.cmd, x: i_in.in_x, y: i_in.in_y, z: i_in.in_z};

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_vec[0] <= n_vec0;
        for (int k = 1; k <= S_RND; k++) begin
            if (w_en[k]) r_vec[k] <= r_vec[k-1];
        end
    end

    //------------------------------------------------------------------
    // S_MUL1: products for q_im x v
    //------------------------------------------------------------------
    logic signed [P1_W-1:0] r_p1 [6];
    logic signed [P1_W-1:0] n_p1 [6];

    always_comb begin
        n_p1[0] = w_qy * i_in.in_z;
        n_p1[1] = w_qz * i_in.in_y;
        n_p1[2] = w_qz * i_in.in_x;
        n_p1[3] = w_qx * i_in.in_z;
        n_p1[4] = w_qx * i_in.in_y;
        n_p1[5] = w_qy * i_in.in_x;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_MUL1]) r_p1 <= n_p1;
    end

    //------------------------------------------------------------------
    // S_CROSS: t = 2 * (q_im x v), each product rounded on its own
    //------------------------------------------------------------------
    logic signed [T_W-1:0] r_t [3];
    logic signed [T_W-1:0] n_t [3];

    always_comb begin
        n_t[0] = rnd29(r_p1[0]) - rnd29(r_p1[1]);
        n_t[1] = rnd29(r_p1[2]) - rnd29(r_p1[3]);
        n_t[2] = rnd29(r_p1[4]) - rnd29(r_p1[5]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_CROSS]) r_t <= n_t;
    end

    //------------------------------------------------------------------
    // S_MUL2: products for w*t and q_im x t
    //   per axis: [w*t, plus term, minus term]
    //------------------------------------------------------------------
    logic signed [P2_W-1:0] r_p2 [9];
    logic signed [P2_W-1:0] n_p2 [9];

    always_comb begin
        n_p2[0] = w_qw * r_t[0];
        n_p2[1] = w_qy * r_t[2];
        n_p2[2] = w_qz * r_t[1];
        n_p2[3] = w_qw * r_t[1];
        n_p2[4] = w_qz * r_t[0];
        n_p2[5] = w_qx * r_t[2];
        n_p2[6] = w_qw * r_t[2];
        n_p2[7] = w_qx * r_t[1];
        n_p2[8] = w_qy * r_t[0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_MUL2]) r_p2 <= n_p2;
    end

    //------------------------------------------------------------------
    // S_RND: scale each product back to Q16.16
    //------------------------------------------------------------------
    logic signed [T_W-1:0] r_rt [9];
    logic signed [T_W-1:0] n_rt [9];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_rt[i] = rnd30(r_p2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_RND]) r_rt <= n_rt;
    end

    //------------------------------------------------------------------
    // S_SUM: r = v + w*t + (q_im x t) [+ translation for points]
    //------------------------------------------------------------------
    logic signed [R_W-1:0] r_r [3];
    logic signed [R_W-1:0] n_r [3];
    t_coord                w_pos [3];
    t_coord                w_v   [3];

    assign w_v[0]   = r_vec[S_RND].x;
    assign w_v[1]   = r_vec[S_RND].y;
    assign w_v[2]   = r_vec[S_RND].z;
    assign w_pos[0] = t_coord'(r_cfg[REG_POS_X]);
    assign w_pos[1] = t_coord'(r_cfg[REG_POS_Y]);
    assign w_pos[2] = t_coord'(r_cfg[REG_POS_Z]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_r[i] = R_W'(w_v[i]) + R_W'(r_rt[3*i]) + R_W'(r_rt[3*i+1])
                   - R_W'(r_rt[3*i+2]);
            if (r_vec[S_RND].cmd == CMD_POINT) begin
                n_r[i] = n_r[i] + R_W'(w_pos[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_SUM]) r_r <= n_r;
    end

    //------------------------------------------------------------------
    // S_OUT: saturate to COORD_WIDTH, output register
    //------------------------------------------------------------------
    t_coord r_out [3];
    t_coord n_out [3];
    logic   r_ovf, n_ovf;

    always_comb begin
        logic signed [63:0] wide;
        n_ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            wide = 64'(r_r[i]);
            if (wide > SAT_HI) begin
                wide  = SAT_HI;
                n_ovf = 1'b1;
            end
            if (wide < SAT_LO) begin
                wide  = SAT_LO;
                n_ovf = 1'b1;
            end
            n_out[i] = wide[FIELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_OUT]) begin
            r_out <= n_out;
            r_ovf <= n_ovf;
        end
    end

    assign o_out.valid    = r_vld[S_OUT];
    assign o_out.out_x    = r_out[0];
    assign o_out.out_y    = r_out[1];
    assign o_out.out_z    = r_out[2];
    assign o_out.overflow = r_ovf;

endmodule

// File: sv/rpt_checker.sv
// Port-level assertions for rigid_pose_transform, attached by bind.
// Depends on rpt_pkg and the top level.
module rpt_checker #(
    parameter int COORD_WIDTH = rpt_pkg::COORD_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input rpt_pkg::t_coord       i_out_x,
    input rpt_pkg::t_coord       i_out_y,
    input rpt_pkg::t_coord       i_out_z,
    input logic                  i_out_overflow,
    input logic                  i_pready
);
    import rpt_pkg::*;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam t_coord HI_W = SAT_HI[FIELD_W-1:0];
    localparam t_coord LO_W = SAT_LO[FIELD_W-1:0];

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_z)
            && $stable(i_out_overflow))
        else $error("result word changed while stalled");

    // an empty output stage lets the whole pipe advance
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    // no result out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    // overflow implies some component sits at a clamp bound
    a_ovf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_overflow |->
            (i_out_x == HI_W || i_out_x == LO_W || i_out_y == HI_W
             || i_out_y == LO_W || i_out_z == HI_W || i_out_z == LO_W))
        else $error("overflow set without a clamped component");

    // APB never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready && (i_out_valid || !i_out_valid || i_in_valid))
        else $error("pready dropped");

endmodule

bind rigid_pose_transform rpt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rpt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_x        (o_out.out_x),
    .i_out_y        (o_out.out_y),
    .i_out_z        (o_out.out_z),
    .i_out_overflow (o_out.overflow),
    .i_pready       (pready)
);

// File: test/rigid_pose_transform_checker.sv
`timescale 1ns / 100ps
// Checker for rigid_pose_transform: watches both word channels and the APB
// register writes, predicts every result and compares it. Depends on rpt_pkg, rpt_if.
module rigid_pose_transform_checker #(
    parameter int COORD_WIDTH = rpt_pkg::COORD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rpt_in_if                          i_vec,
    rpt_out_if                         i_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [rpt_pkg::ADDR_W-1:0] paddr,
    input  logic [rpt_pkg::CFG_W-1:0]  pwdata,
    output int                         o_fail_count,
    output int                         o_pending
);
    import rpt_pkg::*;

    localparam int REG_BYTES    = 4;
    localparam int CROSS_SHIFT  = 29;   // doubled cross product
    localparam int PROD_SHIFT   = 30;   // plain Q1.30 product

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   ovf;
    } t_pose_result;

    logic [CFG_W-1:0] pose_reg [NUM_REGS];
    t_pose_result     predicted_results [$];
    t_pose_result     want;
    int               result_no;
    int               reg_idx;

    // Quaternion term as used: clamped to +-1.0, register keeps raw value
    function automatic longint quat_term(input logic [CFG_W-1:0] raw);
        t_coord sq;
        longint q;
        sq = raw;
        q  = sq;
        if (q > longint'(Q_ONE))  q = Q_ONE;
        if (q < -longint'(Q_ONE)) q = -longint'(Q_ONE);
        return q;
    endfunction

    // round(a*b / 2^sh), ties away from zero
    function automatic longint scaled_product(input longint a, input longint b,
                                              input int sh);
        logic signed [127:0] pa, pb, prod;
        logic        [127:0] mag;
        longint              rounded;
        pa      = a;
        pb      = b;
        prod    = pa * pb;
        mag     = (prod < 0) ? -prod : prod;
        mag     = (mag + (128'd1 << (sh - 1))) >> sh;
        rounded = longint'(mag[63:0]);
        return (prod < 0) ? -rounded : rounded;
    endfunction

    // {clamped flag, low word of the clamped value}
    function automatic logic [FIELD_W:0] clamp_coord(input longint r);
        longint hi, lo;
        hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (r > hi) return {1'b1, hi[FIELD_W-1:0]};
        if (r < lo) return {1'b1, lo[FIELD_W-1:0]};
        return {1'b0, r[FIELD_W-1:0]};
    endfunction

    function automatic t_pose_result transform_vector(input logic cmd, input t_coord ix,
                                                      input t_coord iy, input t_coord iz);
        longint           qx, qy, qz, qw, vx, vy, vz, tx, ty, tz, rx, ry, rz;
        logic [FIELD_W:0] cx, cy, cz;
        t_pose_result     res;
        qx = quat_term(pose_reg[REG_ROT_X]);
        qy = quat_term(pose_reg[REG_ROT_Y]);
        qz = quat_term(pose_reg[REG_ROT_Z]);
        qw = quat_term(pose_reg[REG_ROT_W]);
        vx = ix;
        vy = iy;
        vz = iz;
        // t = 2 * (q_im x v)
        tx = scaled_product(qy, vz, CROSS_SHIFT) - scaled_product(qz, vy, CROSS_SHIFT);
        ty = scaled_product(qz, vx, CROSS_SHIFT) - scaled_product(qx, vz, CROSS_SHIFT);
        tz = scaled_product(qx, vy, CROSS_SHIFT) - scaled_product(qy, vx, CROSS_SHIFT);
        // r = v + w*t + (q_im x t), each product rounded on its own
        rx = vx + scaled_product(qw, tx, PROD_SHIFT) + scaled_product(qy, tz, PROD_SHIFT)
                - scaled_product(qz, ty, PROD_SHIFT);
        ry = vy + scaled_product(qw, ty, PROD_SHIFT) + scaled_product(qz, tx, PROD_SHIFT)
                - scaled_product(qx, tz, PROD_SHIFT);
        rz = vz + scaled_product(qw, tz, PROD_SHIFT) + scaled_product(qx, ty, PROD_SHIFT)
                - scaled_product(qy, tx, PROD_SHIFT);
        if (cmd == CMD_POINT) begin
            rx += longint'(t_coord'(pose_reg[REG_POS_X]));
            ry += longint'(t_coord'(pose_reg[REG_POS_Y]));
            rz += longint'(t_coord'(pose_reg[REG_POS_Z]));
        end
        cx      = clamp_coord(rx);
        cy      = clamp_coord(ry);
        cz      = clamp_coord(rz);
        res.x   = cx[FIELD_W-1:0];
        res.y   = cy[FIELD_W-1:0];
        res.z   = cz[FIELD_W-1:0];
        res.ovf = cx[FIELD_W] | cy[FIELD_W] | cz[FIELD_W];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (pose_reg[i]) pose_reg[i] = '0;
            pose_reg[REG_ROT_W] = Q_ONE;
            predicted_results.delete();
            result_no = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_idx = paddr / REG_BYTES;
                if (reg_idx < NUM_REGS) pose_reg[reg_idx] = pwdata;
            end
            if (i_vec.valid && i_vec.ready) begin
                predicted_results.push_back(
                    transform_vector(i_vec.cmd, i_vec.in_x, i_vec.in_y, i_vec.in_z));
            end
            if (i_res.valid && i_res.ready) begin
                if (predicted_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected word x=%0d y=%0d z=%0d ovf=%0b", $time,
                             i_res.out_x, i_res.out_y, i_res.out_z, i_res.overflow);
                end else begin
                    want = predicted_results.pop_front();
                    if (want.x !== i_res.out_x || want.y !== i_res.out_y ||
                        want.z !== i_res.out_z || want.ovf !== i_res.overflow) begin
                        o_fail_count++;
                        $display({"%0t: word %0d expected x=%0d y=%0d z=%0d ovf=%0b,",
                                  " got x=%0d y=%0d z=%0d ovf=%0b"},
                                 $time, result_no, want.x, want.y, want.z, want.ovf,
                                 i_res.out_x, i_res.out_y, i_res.out_z, i_res.overflow);
                    end
                end
                result_no++;
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

// File: test/rigid_pose_transform_test.sv
`timescale 1ns / 100ps
// Top of the rigid_pose_transform testbench: clock, reset, APB pose writes,
// vector stimulus, back-pressure and verdict. Depends on rpt_pkg, rpt_if, the checker.
module rigid_pose_transform_test;
    import rpt_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int REG_BYTES      = 4;
    localparam int UNUSED_REG     = NUM_REGS;     // index 7: write must be dropped
    localparam int RAND_PHASES    = 8;
    localparam int RAND_WORDS     = 180;          // per random phase
    localparam int PRESSURE_PHASE = 4;            // a phase with a steady sender
    localparam int HOLD_CYCLES    = 240;          // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 2 * NSTG;
    localparam int HEAVY_PCT      = 52;
    localparam int LIGHT_PCT      = 22;
    localparam int SMALL_SPAN     = 1 << 20;      // +-16.0 in Q16.16
    localparam real QUAT_SCALE    = 1073741824.0;

    localparam t_coord COORD_MAX = 32'sh7FFF_FFFF;
    localparam t_coord COORD_MIN = 32'sh8000_0000;
    localparam t_coord HALF_Q    = 32'sh2000_0000;   // 0.5 in Q1.30

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum int {POSE_UNIT, POSE_RAW, POSE_AXIS} t_pose_style;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]  pwdata;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    int failures;
    int results_in_flight;
    int quiet_cycles = 0;

    t_idle_mode idle_mode    = IDLE_NONE;
    bit         pressure_arm = 1'b0;

    // Staging copy of the seven pose registers, in register order
    logic [CFG_W-1:0] pose_words [NUM_REGS];

    rpt_in_if  vec_in ();
    rpt_out_if vec_out ();

    rigid_pose_transform DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (vec_in),
        .o_out   (vec_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rigid_pose_transform_checker pose_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vec        (vec_in),
        .i_res        (vec_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (failures),
        .o_pending    (results_in_flight)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit sender_gap(input t_idle_mode m);
        case (m)
            IDLE_SENDER: return $urandom_range(99) < HEAVY_PCT;
            IDLE_BOTH:   return $urandom_range(99) < LIGHT_PCT;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall(input t_idle_mode m);
        case (m)
            IDLE_RECEIVER: return $urandom_range(99) < HEAVY_PCT;
            IDLE_BOTH:     return $urandom_range(99) < LIGHT_PCT;
            default:       return 1'b0;
        endcase
    endfunction

    // Mostly full-range or small coordinates; a few land on the edges
    function automatic t_coord random_coord();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 4) return t_coord'($urandom);
        if (pick < 8) return t_coord'(int'($urandom_range(2 * SMALL_SPAN)) - SMALL_SPAN);
        case ($urandom_range(4))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    // One word on the input channel; called and returning at a falling edge
    task automatic send_vector(input logic cmd, input t_coord x, input t_coord y,
                               input t_coord z);
        if (sender_gap(idle_mode)) begin
            vec_in.valid <= 1'b0;
            do @(negedge i_clk); while (sender_gap(idle_mode));
        end
        vec_in.valid <= 1'b1;
        vec_in.cmd   <= cmd;
        vec_in.in_x  <= x;
        vec_in.in_y  <= y;
        vec_in.in_z  <= z;
        do @(posedge i_clk); while (!vec_in.ready);
        @(negedge i_clk);
    endtask

    // Setup then access; back-to-back writes keep psel high between them
    task automatic write_reg(input int idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * REG_BYTES);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
    endtask

    // All seven registers plus a write past the end that must be ignored
    task automatic load_pose();
        for (int i = 0; i < NUM_REGS; i++) write_reg(i, pose_words[i]);
        write_reg(UNUSED_REG, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering the last word, then wait for the pipe to empty
    task automatic drain_results();
        vec_in.valid <= 1'b0;
        while (results_in_flight != 0) @(negedge i_clk);
    endtask

    // Corners: zero, both extremes, mixed signs, and small odd values sent
    // once as a point and once as a direction
    task automatic send_directed();
        send_vector(CMD_POINT, 0, 0, 0);
        send_vector(CMD_DIR, COORD_MAX, COORD_MAX, COORD_MAX);
        send_vector(CMD_POINT, COORD_MIN, COORD_MIN, COORD_MIN);
        send_vector(CMD_DIR, COORD_MAX, COORD_MIN, 0);
        send_vector(CMD_POINT, 1, -1, 3);
        send_vector(CMD_DIR, 1, -1, 3);
    endtask

    task automatic pick_pose(input t_pose_style style);
        real comp [4];
        real norm;
        int  axis;
        case (style)
            POSE_UNIT: begin
                // random direction in 4D, normalized; rot_x..rot_w are regs 0..3
                do begin
                    norm = 0.0;
                    for (int i = 0; i < 4; i++) begin
                        comp[i] = real'($urandom_range(2000000)) / 1.0e6 - 1.0;
                        norm += comp[i] * comp[i];
                    end
                end while (norm < 0.01 || norm > 1.0);
                norm = $sqrt(norm);
                for (int i = 0; i < 4; i++)
                    pose_words[i] = CFG_W'($rtoi(comp[i] / norm * QUAT_SCALE));
            end
            POSE_RAW: begin
                // out of range and non-unit; the block clamps on use
                for (int i = 0; i < 4; i++) pose_words[i] = $urandom;
            end
            default: begin
                for (int i = 0; i < 4; i++) pose_words[i] = '0;
                axis = $urandom_range(3);
                pose_words[axis] = $urandom_range(1) ? Q_ONE : -Q_ONE;
            end
        endcase
        for (int i = REG_POS_X; i <= REG_POS_Z; i++) begin
            case ($urandom_range(2))
                0:       pose_words[i] = $urandom;
                1:       pose_words[i] = CFG_W'(int'($urandom_range(2 * SMALL_SPAN)) - SMALL_SPAN);
                default: pose_words[i] = '0;
            endcase
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n      = 1'b0;
        vec_in.valid = 1'b0;
        vec_in.cmd   = CMD_POINT;
        vec_in.in_x  = '0;
        vec_in.in_y  = '0;
        vec_in.in_z  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identity pose from reset
        send_directed();

        // 120 degree turn (all components 0.5), translation at the extremes
        drain_results();
        pose_words[REG_ROT_X] = HALF_Q;
        pose_words[REG_ROT_Y] = HALF_Q;
        pose_words[REG_ROT_Z] = HALF_Q;
        pose_words[REG_ROT_W] = HALF_Q;
        pose_words[REG_POS_X] = COORD_MAX;
        pose_words[REG_POS_Y] = COORD_MIN;
        pose_words[REG_POS_Z] = '0;
        load_pose();
        idle_mode <= IDLE_BOTH;
        send_directed();

        // components beyond +-1.0 get clamped, w = -1.0, non-unit overall
        drain_results();
        pose_words[REG_ROT_X] = COORD_MAX;
        pose_words[REG_ROT_Y] = COORD_MIN;
        pose_words[REG_ROT_Z] = Q_ONE;
        pose_words[REG_ROT_W] = -Q_ONE;
        pose_words[REG_POS_X] = COORD_MIN;
        pose_words[REG_POS_Y] = COORD_MAX;
        pose_words[REG_POS_Z] = '1;
        load_pose();
        idle_mode <= IDLE_SENDER;
        send_directed();

        // random poses, each idling pattern in turn
        for (int r = 0; r < RAND_PHASES; r++) begin
            drain_results();
            if (r == 2 || r == 6)
                pick_pose(POSE_RAW);
            else if (r == 5)
                pick_pose(POSE_AXIS);
            else
                pick_pose(POSE_UNIT);
            load_pose();
            idle_mode <= t_idle_mode'(r % 4);
            if (r == PRESSURE_PHASE) pressure_arm <= 1'b1;
            repeat (RAND_WORDS)
                send_vector(1'($urandom_range(1)), random_coord(), random_coord(),
                            random_coord());
        end
        vec_in.valid <= 1'b0;

        // everything in flight must come out, then a quiet tail for strays
        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stalls by phase, plus one long hold-off so the
    // pipeline fills and the input side has to stall
    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        vec_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_arm && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                vec_out.ready <= 1'b0;
            end else begin
                vec_out.ready <= !receiver_stall(idle_mode);
            end
        end
    end

    // Watchdog: any word moved or register written counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (vec_in.valid && vec_in.ready) || (vec_out.valid && vec_out.ready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: filelist.f
sv/rpt_pkg.sv
sv/rpt_if.sv
sv/rigid_pose_transform.sv
sv/rpt_checker.sv
test/rigid_pose_transform_checker.sv
test/rigid_pose_transform_test.sv
